### sv/sorted_range_list_intersect_core_macros.svh
// Assertion macros shared by the checker of the range-list intersection core.
`ifndef SORTED_RANGE_LIST_INTERSECT_CORE_MACROS_SVH
`define SORTED_RANGE_LIST_INTERSECT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRLI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srli check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRLI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srli check failed");

// Next-cycle implication that is also checked across reset.
`define SRLI_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("srli reset check failed");

`endif

### sv/srli_pkg.sv
// Types and constants shared by the range-list intersection core.
`timescale 1ns / 1ps
package srli_pkg;

  localparam int POS_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int MODE_BITS  = 3;

  typedef logic [POS_BITS-1:0]          pos_t;
  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic [MODE_BITS-1:0]         mode_t;

  localparam mode_t MODE_LEFT      = 3'd0;
  localparam mode_t MODE_RIGHT     = 3'd1;
  localparam mode_t MODE_LEFT_END  = 3'd2;
  localparam mode_t MODE_RIGHT_END = 3'd3;
  localparam mode_t MODE_RESTART   = 3'd4;

  typedef struct packed {
    mode_t mode;
    pos_t  range_start;
    pos_t  range_end;
    val_t  range_value;
  } item_t;

  typedef struct packed {
    pos_t left_lo;
    pos_t left_hi;
    logic left_held;
    pos_t right_lo;
    pos_t right_hi;
    val_t right_val;
    logic right_held;
    logic left_ended;
    logic right_ended;
  } merge_state_t;

  typedef struct packed {
    logic hit;
    pos_t out_start;
    pos_t out_end;
    val_t out_value;
    logic need_left;
    logic need_right;
    logic complete;
    logic slot_error;
  } result_t;

endpackage

### sv/srli_merge.sv
// Combinational merge step: one item against the held slots gives next state and result.
`timescale 1ns / 1ps
module srli_merge (
  input  srli_pkg::item_t        item,
  input  srli_pkg::merge_state_t cur,
  output srli_pkg::merge_state_t nxt,
  output srli_pkg::result_t      res
);
  import srli_pkg::*;

  pos_t         end_fix;
  merge_state_t ld;
  logic         err;
  pos_t         lo_max;
  pos_t         hi_min;

  always_comb begin
    // An inverted range collapses to its start position.
    end_fix = (item.range_end < item.range_start) ? item.range_start : item.range_end;
    ld      = cur;
    err     = 1'b0;
    unique case (item.mode)
      MODE_LEFT: begin
        if (cur.left_held || cur.left_ended) begin
          err = 1'b1;
        end else begin
          ld.left_lo   = item.range_start;
          ld.left_hi   = end_fix;
          ld.left_held = 1'b1;
        end
      end
      MODE_RIGHT: begin
        if (cur.right_held || cur.right_ended) begin
          err = 1'b1;
        end else begin
          ld.right_lo   = item.range_start;
          ld.right_hi   = end_fix;
          ld.right_val  = item.range_value;
          ld.right_held = 1'b1;
        end
      end
      MODE_LEFT_END:  ld.left_ended  = 1'b1;
      MODE_RIGHT_END: ld.right_ended = 1'b1;
      MODE_RESTART:   ld = '0;
      default:        ld = cur;
    endcase
  end

  always_comb begin
    lo_max        = (ld.left_lo > ld.right_lo) ? ld.left_lo : ld.right_lo;
    hi_min        = (ld.left_hi < ld.right_hi) ? ld.left_hi : ld.right_hi;
    nxt           = ld;
    res           = '0;
    res.slot_error = err;
    if (ld.left_held && ld.right_held) begin
      if (ld.left_hi < ld.right_lo) begin
        nxt.left_held = 1'b0;
      end else if (ld.right_hi < ld.left_lo) begin
        nxt.right_held = 1'b0;
      end else begin
        res.hit       = 1'b1;
        res.out_start = lo_max;
        res.out_end   = hi_min;
        res.out_value = ld.right_val;
        if (ld.left_hi == hi_min) begin
          nxt.left_held = 1'b0;
        end
        if (ld.right_hi == hi_min) begin
          nxt.right_held = 1'b0;
        end
      end
    end
    res.need_left  = !nxt.left_held && !nxt.left_ended;
    res.need_right = !nxt.right_held && !nxt.right_ended;
    res.complete   = (nxt.left_ended && !nxt.left_held) ||
                     (nxt.right_ended && !nxt.right_held);
  end

endmodule

### sv/srli_skid.sv
// Two-entry result buffer that decouples the merge stage from the output stall.
`timescale 1ns / 1ps
module srli_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srli_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output srli_pkg::result_t out_data
);
  import srli_pkg::*;

  result_t    entry_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       pop;

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/sorted_range_list_intersect_core.sv
// An accepted beat waits in the input register; its merged result goes into the result buffer.
// Throughput: one beat per cycle while the buffer has room; the merge step is combinational.
// A two-entry result buffer lets a new beat enter while a finished result is still stalled.
// Reset (rst_n low, synchronous): both slots empty, both streams open, all buffers empty.
// A restart beat clears the same merge state as reset and yields one result with no hit.
`timescale 1ns / 1ps
module sorted_range_list_intersect_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  srli_pkg::mode_t        in_mode,
  input  srli_pkg::pos_t         in_range_start,
  input  srli_pkg::pos_t         in_range_end,
  input  srli_pkg::val_t         in_range_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_hit,
  output srli_pkg::pos_t         out_start,
  output srli_pkg::pos_t         out_end,
  output srli_pkg::val_t         out_value,
  output logic                   out_need_left,
  output logic                   out_need_right,
  output logic                   out_complete,
  output logic                   out_slot_error
);
  import srli_pkg::*;

  // Input register: the beat waits here until the result buffer has room.
  logic         s1_valid_r;
  logic         s1_valid_nxt;
  item_t        s1_item_r;
  logic         in_accept;
  logic         advance;
  logic         skid_full;

  // Merge state: the left and right slots and the end-of-stream flags.
  merge_state_t st_r;
  merge_state_t st_nxt;
  result_t      step_res;
  result_t      out_res;

  // The stall is taken from the registered buffer fill, never from out_stall directly.
  assign in_stall  = s1_valid_r && skid_full;
  assign in_accept = in_valid && !in_stall;
  assign advance   = s1_valid_r && !skid_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= '{mode: in_mode, range_start: in_range_start,
                     range_end: in_range_end, range_value: in_range_value};
    end
  end

  // One merge step per beat: load or flag the slot, or clear all on restart, then drop or intersect.
  srli_merge u_merge (
    .item (s1_item_r),
    .cur  (st_r),
    .nxt  (st_nxt),
    .res  (step_res)
  );

  // The state moves only when the beat's result is written into the buffer,
  // so a stalled beat is merged exactly once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  srli_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .push_data (step_res),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_hit        = out_res.hit;
  assign out_start      = out_res.out_start;
  assign out_end        = out_res.out_end;
  assign out_value      = out_res.out_value;
  assign out_need_left  = out_res.need_left;
  assign out_need_right = out_res.need_right;
  assign out_complete   = out_res.complete;
  assign out_slot_error = out_res.slot_error;

endmodule

### sv/srli_checker.sv
// Port-level checker for the range-list intersection core and its bind.
`timescale 1ns / 1ps
`include "sorted_range_list_intersect_core_macros.svh"
module srli_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input logic           out_hit,
  input srli_pkg::pos_t out_start,
  input srli_pkg::pos_t out_end,
  input srli_pkg::val_t out_value,
  input logic           out_slot_error
);
  import srli_pkg::*;

  // A result without a hit carries an all-zero range and value.
  `SRLI_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, out_start == '0 && out_end == '0 && out_value == '0)
  // An intersection is never inverted.
  `SRLI_ASSERT_NOW(a_hit_ordered, out_valid && out_hit, out_start <= out_end)
  // An ignored range leaves at most one slot held, so no intersection can come with it.
  `SRLI_ASSERT_NOW(a_err_no_hit, out_valid && out_slot_error, !out_hit)
  // A stalled result holds its payload.
  `SRLI_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_start) && $stable(out_end) && $stable(out_value) && $stable(out_hit))
  // Reset empties the result buffer.
  `SRLI_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind sorted_range_list_intersect_core srli_checker u_srli_checker (.*);
